/* src/mris_pkg.sv */
// Package for the multi-resource interval scheduler: payload structs and shared constants.
// No dependencies.
package mris_pkg;

    localparam int TIME_W = 31;
    localparam int CNT_W  = 11;
    localparam int CFG_W  = 5;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              last_item;
    } in_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] accepted_count;
        logic             overflow;
    } out_word_t;

endpackage

/* src/multi_resource_interval_scheduler.sv */
// Top level of the multi-resource greedy interval scheduler.
// Depends on mris_pkg and mris_ram.
//
// Usage: input words (start_time, end_time, last_item) arrive on the s_ channel,
// one per cycle while the block is loading. Each word is written into the interval
// memory. A word marked last_item ends the job: the block stops accepting, runs a
// bottom-up stable merge sort by end time between two memories (ping-pong, one
// element merged per cycle once each merge run has started), then walks the
// sorted list once, checking the resources one per cycle in order. When the walk
// is done the single result word (accepted_count, overflow) is shown on m_.
// The sort has a single read port per memory.
// Words beyond MAX_ITEMS are dropped and reported through overflow.
// At reset the block is empty, the resource setting is 1 and free times are zero.
// If the receiver stalls, the result stays on m_ and no new word is accepted
// until it is taken; resource free times are cleared when a last_item word is taken.
module multi_resource_interval_scheduler #(
    parameter int MAX_ITEMS     = 1024,
    parameter int MAX_RESOURCES = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [4:0]              cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  mris_pkg::in_word_t      s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output mris_pkg::out_word_t     m_data
);
    import mris_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int NW = AW + 1;
    localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int EW = 2 * TIME_W;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1; // start a merge run, pass to the next width, or begin the walk
    localparam logic [2:0] ST_MERGE = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3; // issue read of next sorted word
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_WAIT  = 3'd6; // read latency at the start of a merge run

    logic [2:0]  state_reg;
    logic [NW-1:0] count_reg;
    logic        ovf_reg;
    logic [CFG_W-1:0] res_reg;
    logic        src_reg;          // which memory holds the current sorted data
    logic [NW:0] width_reg, lo_reg, a_reg, b_reg, mid_reg, hi_reg, k_reg;
    logic [TIME_W-1:0] free_reg [MAX_RESOURCES];
    logic [RW-1:0] r_reg;
    logic [CNT_W-1:0] acc_reg;
    logic [EW-1:0] cur_reg;
    logic        fetch_a_reg;      // last fetch refilled side a

    // Each memory has one read port; during the merge side a and side b are held in
    // registers and only the consumed side is refetched.
    logic [EW-1:0] ea_reg, eb_reg;
    logic          pend_reg;       // a refetch is in flight

    logic        we0, we1;
    logic [AW-1:0] wa0, wa1, ra0, ra1;
    logic [EW-1:0] wd, rd0, rd1, rd_src;
    logic [AW-1:0] raddr;

    mris_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_ram0 (
        .aclk(aclk), .wr_en(we0), .wr_addr(wa0), .wr_data(wd),
        .rd_addr(ra0), .rd_data(rd0));
    mris_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_ram1 (
        .aclk(aclk), .wr_en(we1), .wr_addr(wa1), .wr_data(wd),
        .rd_addr(ra1), .rd_data(rd1));

    assign rd_src = src_reg ? rd1 : rd0;
    assign ra0 = raddr;
    assign ra1 = raddr;

    logic [CFG_W-1:0] m_eff;
    assign m_eff = (int'(res_reg) > MAX_RESOURCES) ? CFG_W'(MAX_RESOURCES) : res_reg;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data.accepted_count = acc_reg;
    assign m_data.overflow = ovf_reg;

    logic s_acc;
    assign s_acc = s_valid && s_ready;

    // Side values used by the merge compare (forwarded from the read port when fresh).
    logic [EW-1:0] va, vb;
    assign va = (pend_reg && fetch_a_reg) ? rd_src : ea_reg;
    assign vb = (pend_reg && !fetch_a_reg) ? rd_src : eb_reg;
    logic take_a;
    assign take_a = (a_reg < mid_reg) &&
                    ((b_reg >= hi_reg) || (va[TIME_W-1:0] <= vb[TIME_W-1:0]));

    logic [NW:0] n_ext;
    assign n_ext = {1'b0, count_reg};

    always_comb begin
        we0 = 1'b0;
        we1 = 1'b0;
        wa0 = '0;
        wa1 = '0;
        wd  = '0;
        raddr = '0;
        if (state_reg == ST_LOAD) begin
            we0 = s_acc && (count_reg < NW'(MAX_ITEMS));
            wa0 = count_reg[AW-1:0];
            wd  = {s_data.start_time, s_data.end_time};
        end else if (state_reg == ST_MERGE) begin
            wd = take_a ? va : vb;
            we0 = src_reg;
            we1 = !src_reg;
            wa0 = k_reg[AW-1:0];
            wa1 = k_reg[AW-1:0];
            raddr = take_a ? AW'(a_reg + 1'b1) : AW'(b_reg + 1'b1);
        end else if (state_reg == ST_RUN) begin
            raddr = lo_reg[AW-1:0];
        end else if (state_reg == ST_WAIT) begin
            raddr = mid_reg[AW-1:0];
        end else if (state_reg == ST_WALK) begin
            raddr = k_reg[AW-1:0];
        end
    end

    integer i;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            res_reg   <= CFG_W'(1);
            src_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            acc_reg   <= '0;
            for (i = 0; i < MAX_RESOURCES; i++) free_reg[i] <= '0;
        end else begin
            if (cfg_wr_en) res_reg <= cfg_wr_data;
            pend_reg <= 1'b0;
            case (state_reg)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (count_reg < NW'(MAX_ITEMS)) count_reg <= count_reg + 1'b1;
                        else ovf_reg <= 1'b1;
                        if (s_data.last_item) begin
                            state_reg <= ST_RUN;
                            width_reg <= (NW+1)'(1);
                            lo_reg <= '0;
                            src_reg <= 1'b0;
                            acc_reg <= '0;
                            for (i = 0; i < MAX_RESOURCES; i++) free_reg[i] <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    if (width_reg >= n_ext) begin
                        k_reg <= '0;
                        state_reg <= ST_WALK;
                    end else if (lo_reg >= n_ext) begin
                        lo_reg <= '0;
                        width_reg <= width_reg << 1;
                        src_reg <= !src_reg;
                    end else begin
                        a_reg <= lo_reg;
                        k_reg <= lo_reg;
                        mid_reg <= (lo_reg + width_reg > n_ext) ? n_ext : lo_reg + width_reg;
                        hi_reg <= (lo_reg + (width_reg << 1) > n_ext) ? n_ext
                                  : lo_reg + (width_reg << 1);
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    ea_reg <= rd_src;      // word at lo, read in ST_RUN
                    b_reg <= mid_reg;
                    pend_reg <= 1'b1;      // word at mid arrives next cycle
                    fetch_a_reg <= 1'b0;
                    state_reg <= ST_MERGE;
                end
                ST_MERGE: begin
                    ea_reg <= va;
                    eb_reg <= vb;
                    pend_reg <= 1'b1;
                    fetch_a_reg <= take_a;
                    if (take_a) a_reg <= a_reg + 1'b1;
                    else b_reg <= b_reg + 1'b1;
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 >= hi_reg) begin
                        lo_reg <= hi_reg;
                        state_reg <= ST_RUN;
                    end
                end
                ST_WALK: begin
                    r_reg <= '0;
                    if (k_reg >= n_ext) state_reg <= ST_OUT;
                    else state_reg <= ST_SCAN;
                    pend_reg <= 1'b1;
                end
                ST_SCAN: begin
                    if (pend_reg) begin
                        cur_reg <= rd_src;
                    end else if ({1'b0, r_reg} >= (RW+1)'(m_eff) ||
                                 m_eff == '0) begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= ST_WALK;
                    end else if (cur_reg[EW-1:TIME_W] >= free_reg[r_reg]) begin
                        free_reg[r_reg] <= cur_reg[TIME_W-1:0];
                        acc_reg <= acc_reg + 1'b1;
                        k_reg <= k_reg + 1'b1;
                        state_reg <= ST_WALK;
                    end else if (r_reg == RW'(MAX_RESOURCES - 1)) begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= ST_WALK;
                    end else begin
                        r_reg <= r_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_LOAD;
                        count_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule

/* src/mris_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mris_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* src/mris_checker.sv */
// Port-level checker for the interval scheduler, bound to the top level.
// Depends on mris_pkg.
module mris_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mris_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mris_pkg::out_word_t m_data
);
    import mris_pkg::*;

    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while a result waits");

    a_last_stops_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_item) |=> !s_ready)
        else $error("input still open after the last word");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready) else $error("input not reopened");
endmodule

bind multi_resource_interval_scheduler mris_checker u_mris_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

/* test/tb_multi_resource_interval_scheduler.sv */
// Testbench for the multi-resource greedy interval scheduler: drives jobs of intervals,
// predicts each job's accepted count and overflow flag, and checks every result word.
// Depends on mris_pkg and the multi_resource_interval_scheduler RTL.
module tb_multi_resource_interval_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import mris_pkg::*;

    localparam int STORE_DEPTH   = 1024;
    localparam int RESOURCE_MAX  = 16;
    localparam int TIME_TOP      = 2147483646;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 2000;

    logic      aclk;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [4:0] cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // Predictor state: the register as written, the intervals of the open job in
    // arrival order, and the result words still owed by the block.
    logic [4:0] resources_setting;
    in_word_t   open_job[$];
    int         open_job_len;
    out_word_t  owed_results[$];

    int  error_count;
    int  cycle_count;
    bit  sender_steady;
    bit  receiver_steady;
    int  receiver_hold;
    int  receiver_wait;

    multi_resource_interval_scheduler uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // A mismatch or an unexpected word prints one line and is counted.
    task automatic report(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Works out the result of the job that just closed. The store keeps only
    // the first STORE_DEPTH intervals; the rest only raise the overflow flag.
    // Stable sort by end time is an insertion that goes after every equal key,
    // then each interval goes to the lowest resource already free at its start.
    function automatic out_word_t close_job_prediction();
        in_word_t   by_end[$];
        logic [30:0] free_at [RESOURCE_MAX];
        int         pos;
        int         usable;
        int         taken;
        out_word_t  res;
        for (int r = 0; r < RESOURCE_MAX; r++) free_at[r] = '0;
        foreach (open_job[i]) begin
            pos = by_end.size();
            while (pos > 0 && by_end[pos-1].end_time > open_job[i].end_time) pos--;
            by_end.insert(pos, open_job[i]);
        end
        usable = (int'(resources_setting) > RESOURCE_MAX) ? RESOURCE_MAX
                                                          : int'(resources_setting);
        taken = 0;
        foreach (by_end[i]) begin
            for (int r = 0; r < usable; r++) begin
                if (by_end[i].start_time >= free_at[r]) begin
                    free_at[r] = by_end[i].end_time;
                    taken++;
                    break;
                end
            end
        end
        res.accepted_count = taken[CNT_W-1:0];
        res.overflow       = (open_job_len > STORE_DEPTH);
        return res;
    endfunction

    // Offers one word after a random gap and waits for the handshake. Valid is
    // left high afterwards so that a back-to-back word needs no second drive.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (open_job_len < STORE_DEPTH) open_job.insert(open_job.size(), w);
        open_job_len++;
        if (w.last_item) begin
            owed_results.insert(owed_results.size(), close_job_prediction());
            open_job.delete();
            open_job_len = 0;
        end
    endtask

    task automatic sender_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every owed word has arrived, then lets the block settle.
    task automatic drain();
        sender_idle();
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The register is only written while the block is idle.
    task automatic set_resources(input logic [4:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        resources_setting = value;
        @(posedge aclk);
    endtask

    function automatic in_word_t make_interval(input bit full_range, input bit last);
        in_word_t w;
        int unsigned len;
        if (full_range) begin
            w.start_time = TIME_W'($urandom_range(0, TIME_TOP));
            w.end_time   = TIME_W'($urandom_range(0, TIME_TOP));
        end else begin
            w.start_time = TIME_W'($urandom_range(0, 60));
            len          = $urandom_range(0, 20);
            w.end_time   = TIME_W'(w.start_time + len);
        end
        w.last_item = last;
        return w;
    endfunction

    task automatic send_job(input int len, input int wide_percent);
        for (int i = 0; i < len; i++)
            send_word(make_interval($urandom_range(0, 99) < wide_percent, i == len - 1));
    endtask

    task automatic send_pair(input int st, input int en, input bit last);
        in_word_t w;
        w.start_time = TIME_W'(st);
        w.end_time   = TIME_W'(en);
        w.last_item  = last;
        send_word(w);
    endtask

    // Field extremes, ties on end time, start after end, a lone interval, and
    // the zero and oversized resource settings.
    task automatic test_directed();
        set_resources(5'd1);
        send_pair(0, 0, 1);
        send_pair(TIME_TOP, TIME_TOP, 1);
        send_pair(TIME_TOP, 0, 0);
        send_pair(0, TIME_TOP, 0);
        send_pair(5, 3, 1);
        set_resources(5'd2);
        // Equal end times: arrival order decides which resource each one takes.
        send_pair(4, 10, 0);
        send_pair(0, 10, 0);
        send_pair(10, 10, 0);
        send_pair(2, 10, 1);
        send_pair(1, 5, 0);
        send_pair(5, 9, 0);
        send_pair(0, 9, 0);
        send_pair(9, TIME_TOP, 1);
        set_resources(5'd0);
        send_pair(0, 1, 0);
        send_pair(1, 2, 1);
        set_resources(5'd31);
        for (int i = 0; i < 8; i++) send_pair(0, 100 + i, i == 7);
        set_resources(5'd16);
        send_pair(0, 0, 0);
        send_pair(0, 0, 1);
    endtask

    // Random jobs under many settings; most intervals sit in a narrow window so
    // that they overlap and contend for resources, some span the whole range.
    task automatic test_resource_settings();
        logic [4:0] settings [10] = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd7, 5'd16,
                                      5'd0, 5'd31, 5'd17, 5'd5};
        int items;
        foreach (settings[k]) begin
            set_resources(settings[k]);
            sender_steady   = (k == 3);
            receiver_steady = (k == 3);
            items = 0;
            while (items < 12) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                send_job(len, ($urandom_range(0, 3) == 0) ? 100 : 10);
                items += len;
            end
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // One job past the store's capacity, ended by a dropped word, then a small
    // job to show the overflow flag is cleared again.
    task automatic test_overflow();
        set_resources(5'd16);
        sender_steady = 1'b1;
        send_job(STORE_DEPTH + 3, 20);
        sender_steady = 1'b0;
        drain();
        send_job(4, 0);
    endtask

    // The receiver holds off for a long stretch while jobs keep coming, so the
    // block fills with a finished result and stops taking words.
    task automatic test_backpressure();
        set_resources(5'd3);
        receiver_hold = LONG_HOLD;
        for (int j = 0; j < 4; j++) send_job(6, 0);
        // Pause until every owed word has come back before going on.
        drain();
        for (int j = 0; j < 3; j++) send_job($urandom_range(1, 8), 10);
    endtask

    // Receiver: checks each accepted word against the oldest prediction and
    // draws a fresh stall after every handshake.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            receiver_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    report("result word with no job waiting");
                end else begin
                    if (m_data.accepted_count !== owed_results[0].accepted_count)
                        report($sformatf("accepted_count got %0d want %0d",
                               m_data.accepted_count, owed_results[0].accepted_count));
                    if (m_data.overflow !== owed_results[0].overflow)
                        report($sformatf("overflow got %0b want %0b",
                               m_data.overflow, owed_results[0].overflow));
                    void'(owed_results.pop_front());
                end
                receiver_wait = receiver_steady ? 0 : $urandom_range(0, 5);
            end
            if (receiver_hold > 0) begin
                receiver_hold--;
                m_ready <= 1'b0;
            end else if (receiver_wait > 0) begin
                receiver_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        error_count     = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        receiver_hold   = 0;
        open_job_len    = 0;
        resources_setting = 5'd1;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_resource_settings();
        test_overflow();
        test_backpressure();

        drain();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/mris_pkg.sv
src/mris_ram.sv
src/multi_resource_interval_scheduler.sv
src/mris_checker.sv
test/tb_multi_resource_interval_scheduler.sv
